FILE: hw/rtl/stbs_pkg.sv
// Shared constants and types for the sorted-table binary search block.
// No dependencies; imported by the controller, the datapath and the top level.
package stbs_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  // Signed bound width: lo reaches TABLE_DEPTH, hi reaches -1, lo+hi needs one more bit.
  localparam int BND_W       = IDX_W + 2;

  localparam int FUNC_W   = 1;
  localparam int INDEX_W  = 5;
  localparam int VALUE_W  = 31;
  localparam int TARGET_W = 32;
  localparam int POS_W    = 5;
  localparam int USED_W   = 6;

  localparam logic [FUNC_W-1:0] FUNC_WRITE  = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_SEARCH = 1'b1;

  typedef logic signed [BND_W-1:0] bound_t;
  typedef logic [IDX_W-1:0]        addr_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic wr;         // store one table entry
    logic start;      // begin a search: load bounds and target
    logic probe;      // compute midpoint and read the table
    logic update;     // compare read data and narrow the bounds
    logic result_ld;  // load the output register
  } stbs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic done;       // match met or range exhausted
  } stbs_stat_t;

endpackage

FILE: hw/rtl/stbs_dp.sv
// Datapath: table memory, entries_used register, search bounds, compare and result register.
// Depends on stbs_pkg.
module stbs_dp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  stbs_pkg::stbs_cmd_t                  cmd_i,
  output stbs_pkg::stbs_stat_t                 stat_o,
  input  logic                                 cfg_we_i,
  input  logic [stbs_pkg::USED_W-1:0]          cfg_data_i,
  input  logic [stbs_pkg::INDEX_W-1:0]         entry_index_i,
  input  logic [stbs_pkg::VALUE_W-1:0]         entry_value_i,
  input  logic signed [stbs_pkg::TARGET_W-1:0] target_i,
  output logic                                 found_o,
  output logic [stbs_pkg::POS_W-1:0]           position_o
);
  import stbs_pkg::*;

  logic [VALUE_W-1:0] table_mem [TABLE_DEPTH];

  logic [USED_W-1:0]    entries_used_q;
  bound_t               lo_q, hi_q;
  bound_t               span;
  bound_t               mid_sum;
  bound_t               mid;
  addr_t                mid_q;
  logic [VALUE_W-1:0]   rdata_q;
  logic signed [TARGET_W-1:0] target_q;
  logic signed [TARGET_W-1:0] entry;
  logic                 hit_q;
  logic                 found_q;
  logic [POS_W-1:0]     pos_q;

  assign span = (int'(entries_used_q) > TABLE_DEPTH) ? BND_W'(TABLE_DEPTH)
                                                     : BND_W'(entries_used_q);
  assign mid_sum = lo_q + hi_q;
  assign mid     = mid_sum >>> 1;
  assign entry   = $signed({1'b0, rdata_q});

  assign stat_o.done = hit_q || (lo_q > hi_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entries_used_q <= '0;
    end else if (cfg_we_i) begin
      entries_used_q <= cfg_data_i;
    end
  end

  // Table memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr && (int'(entry_index_i) < TABLE_DEPTH)) begin
      table_mem[addr_t'(entry_index_i)] <= entry_value_i;
    end
    if (cmd_i.probe) begin
      rdata_q <= table_mem[addr_t'(mid)];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else if (cmd_i.start) begin
      hit_q <= 1'b0;
    end else if (cmd_i.update && (target_q == entry)) begin
      hit_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      lo_q     <= '0;
      hi_q     <= span - bound_t'(1);
      target_q <= target_i;
    end
    if (cmd_i.probe) begin
      mid_q <= addr_t'(mid);
    end
    if (cmd_i.update && (target_q != entry)) begin
      if (target_q < entry) begin
        hi_q <= bound_t'(mid_q) - bound_t'(1);
      end else begin
        lo_q <= bound_t'(mid_q) + bound_t'(1);
      end
    end
    if (cmd_i.result_ld) begin
      found_q <= hit_q;
      pos_q   <= hit_q ? POS_W'(mid_q) : '0;
    end
  end

  assign found_o    = found_q;
  assign position_o = pos_q;

`ifndef SYNTHESIS
  // An empty range finishes at once.
  a_empty_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.start && (entries_used_q == '0)) |=> stat_o.done)
    else $error("empty search range not flagged done");

  // A probe only happens on a live range.
  a_probe_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.probe |-> (!hit_q && (lo_q <= hi_q) && (lo_q >= 0)))
    else $error("probe issued on exhausted range");

  // A hit is only raised by an equal compare.
  a_hit_equal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(hit_q) |-> $past(cmd_i.update && (target_q == entry)))
    else $error("hit raised without a match");
`endif

endmodule

FILE: hw/rtl/stbs_ctrl.sv
// Controller: sequences table writes, search probes and the output handshake.
// Depends on stbs_pkg.
module stbs_ctrl (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [stbs_pkg::FUNC_W-1:0]      func_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output stbs_pkg::stbs_cmd_t              cmd_o,
  input  stbs_pkg::stbs_stat_t             stat_i
);
  import stbs_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_CMP,
    ST_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   in_take;
  logic   slot_free;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_take    = in_valid_i && !in_stall_o;
  assign slot_free  = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_take) begin
          if (func_i == FUNC_SEARCH) begin
            cmd_o.start = 1'b1;
            state_d     = ST_PROBE;
          end else begin
            cmd_o.wr = 1'b1;
          end
        end
      end
      ST_PROBE: begin
        if (stat_i.done) begin
          state_d = ST_FINISH;
        end else begin
          cmd_o.probe = 1'b1;
          state_d     = ST_CMP;
        end
      end
      ST_CMP: begin
        cmd_o.update = 1'b1;
        state_d      = ST_PROBE;
      end
      ST_FINISH: begin
        if (slot_free) begin
          cmd_o.result_ld = 1'b1;
          out_valid_d     = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  // The output register is never overwritten while a result is held.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.result_ld |-> slot_free)
    else $error("result register overwritten while stalled");

  // A search transaction blocks the input until its result is produced.
  a_search_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_take && (func_i == FUNC_SEARCH)) |=> in_stall_o)
    else $error("input not stalled during search");

  // A write transaction never produces a result.
  a_write_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_take && (func_i == FUNC_WRITE)) |=> !cmd_o.result_ld)
    else $error("write transaction produced a result");
`endif

endmodule

FILE: hw/rtl/sorted_table_binary_search.sv
// Sorted-table binary search. A write transaction gives no result.
// After accept, a search runs a probe state and a compare state per probe, then a range check and a result load,
// at most ceil(log2(depth+1)) probes; no new search is taken until its result is produced.
// Input stalls during a search; a stalled output result holds the search in its last state.
// Reset clears entries_used and the output valid; table contents stay undefined until written.
// Depends on stbs_pkg, stbs_ctrl and stbs_dp.
module sorted_table_binary_search (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [stbs_pkg::FUNC_W-1:0]          func_i,
  input  logic [stbs_pkg::INDEX_W-1:0]         entry_index_i,
  input  logic [stbs_pkg::VALUE_W-1:0]         entry_value_i,
  input  logic signed [stbs_pkg::TARGET_W-1:0] target_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic                                 found_o,
  output logic [stbs_pkg::POS_W-1:0]           position_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [stbs_pkg::USED_W-1:0]          cfg_data_i
);
  import stbs_pkg::*;

  stbs_cmd_t  cmd;
  stbs_stat_t stat;

  assign cfg_ready_o = 1'b1;

  stbs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .func_i      (func_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  stbs_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .cfg_we_i      (cfg_valid_i && cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .entry_index_i (entry_index_i),
    .entry_value_i (entry_value_i),
    .target_i      (target_i),
    .found_o       (found_o),
    .position_o    (position_o)
  );

endmodule
